>>> src/vgrt_pkg.sv
// Shared types, constants and codes for the voxel grid ray traversal block.
`default_nettype none
package vgrt_pkg;

   localparam int GRID_SIDE_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 20;
   localparam int DIR_W    = 16;
   localparam int VS_W     = 8;
   localparam int STATUS_W = 2;
   localparam int HIT_W    = 4;
   // Cell coordinates are wider than the default side needs, so that a step past either edge reads as >= side.
   localparam int CELL_W   = 7;
   // Integer part of a Q12.8 position.
   localparam int CQ_W     = POS_W - 8;
   localparam int T_W      = 40;
   // Numerators of the t divisions: distance << 22 and voxel size << 30.
   localparam int TN_W     = 38;

   localparam logic [VS_W-1:0] VS_RESET = 8'd16;
   localparam logic [T_W-1:0]  T_SAT    = '1;

   localparam logic [FUNC_W-1:0] FN_SET    = 3'd0;
   localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_WALL   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_PILLAR = 3'd3;
   localparam logic [FUNC_W-1:0] FN_RAY    = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_OUTSIDE  = 2'd1,
      ST_RAY_EXIT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_SET,
      OP_CLEAR,
      OP_WALL,
      OP_PILLAR,
      OP_RAY,
      OP_NOP,
      OP_OUTSIDE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [CELL_W-1:0] cx;
      logic [CELL_W-1:0] cy;
      logic [CELL_W-1:0] cz;
      logic              nx;
      logic              ny;
      logic              nz;
      logic [T_W-1:0]    tmx;
      logic [T_W-1:0]    tmy;
      logic [T_W-1:0]    tmz;
      logic [T_W-1:0]    tdx;
      logic [T_W-1:0]    tdy;
      logic [T_W-1:0]    tdz;
   } cmd_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CELL,
      F_TSET,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_POINT,
      B_WALL,
      B_PILLAR,
      B_STEP,
      B_TEST,
      B_OUT
   } back_state_type;

endpackage
`default_nettype wire

>>> src/vgrt_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module vgrt_div #(
   parameter int NUM_W = 12,
   parameter int DEN_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo,
   output logic      [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

>>> src/vgrt_front.sv
// Front end: takes requests, finds the cells and prepares the ray stepping values.
`default_nettype none
module vgrt_front
   import vgrt_pkg::*;
#(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [POS_W-1:0]  req_pos_x,
   input  wire logic [POS_W-1:0]  req_pos_y,
   input  wire logic [POS_W-1:0]  req_pos_z,
   input  wire logic [DIR_W-1:0]  req_dir_x,
   input  wire logic [DIR_W-1:0]  req_dir_y,
   input  wire logic [DIR_W-1:0]  req_dir_z,
   input  wire logic [VS_W-1:0]   voxel_size,
   input  wire logic              clearing,
   input  wire logic              q_full,
   output logic                   push,
   output cmd_type                push_cmd
);
   front_state_type state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [VS_W-1:0]   vs_ff, vs_in;
   op_type            op_ff, op_in;
   op_type            op_cls;
   logic [2:0][7:0]       frac_ff, frac_in;
   logic [2:0][DIR_W-1:0] dir_ff, dir_in;

   logic              accept;
   logic [VS_W-1:0]   vs_eff;
   logic [2:0][CQ_W-1:0]  cnum;
   logic [2:0][CQ_W-1:0]  cq;
   logic [2:0][VS_W-1:0]  crem;
   logic [2:0]            cdone;
   logic [2:0][DIR_W-1:0] mag;
   logic [2:0][15:0]      bound_gap;
   logic [2:0][TN_W-1:0]  tmax_q;
   logic [2:0][TN_W-1:0]  tdel_q;
   logic [2:0][DIR_W-1:0] tmax_r;
   logic [2:0][DIR_W-1:0] tdel_r;
   logic [2:0]            tdone_max;
   logic [2:0]            tdone_del;
   logic [2:0][T_W-1:0]   tm;
   logic [2:0][T_W-1:0]   td;
   logic                  t_start;
   logic                  outside;

   assign accept = req_valid && !req_stall;
   assign vs_eff = (voxel_size == '0) ? VS_W'(1) : voxel_size;
   assign cnum[0] = req_pos_x[POS_W-1:8];
   assign cnum[1] = req_pos_y[POS_W-1:8];
   assign cnum[2] = req_pos_z[POS_W-1:8];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      // Cell index is the integer position divided by the voxel size.
      vgrt_div #(.NUM_W(CQ_W), .DEN_W(VS_W)) u_cell_div (
         .clock (clock),
         .reset (reset),
         .start (accept),
         .num   (cnum[a]),
         .den   (vs_eff),
         .done  (cdone[a]),
         .quo   (cq[a]),
         .rem   (crem[a])
      );

      assign mag[a]  = dir_ff[a][DIR_W-1] ? DIR_W'(~dir_ff[a] + DIR_W'(1)) : dir_ff[a];
      // Distance to the next boundary; the remainder is the offset inside the cell.
      assign bound_gap[a] = dir_ff[a][DIR_W-1] ? {crem[a], frac_ff[a]}
                                               : {vs_ff, 8'h00} - {crem[a], frac_ff[a]};

      vgrt_div #(.NUM_W(TN_W), .DEN_W(DIR_W)) u_tmax_div (
         .clock (clock),
         .reset (reset),
         .start (t_start),
         .num   ({bound_gap[a], 22'b0}),
         .den   (mag[a]),
         .done  (tdone_max[a]),
         .quo   (tmax_q[a]),
         .rem   (tmax_r[a])
      );

      vgrt_div #(.NUM_W(TN_W), .DEN_W(DIR_W)) u_tdel_div (
         .clock (clock),
         .reset (reset),
         .start (t_start),
         .num   ({vs_ff, 30'b0}),
         .den   (mag[a]),
         .done  (tdone_del[a]),
         .quo   (tdel_q[a]),
         .rem   (tdel_r[a])
      );

      // A zero component never crosses a boundary on its axis.
      assign tm[a] = (dir_ff[a] == '0) ? T_SAT : T_W'(tmax_q[a]);
      assign td[a] = (dir_ff[a] == '0) ? T_SAT : T_W'(tdel_q[a]);
   end

   always_comb begin
      outside = (cq[0] >= CQ_W'(GRID_SIDE)) || (cq[1] >= CQ_W'(GRID_SIDE))
             || (cq[2] >= CQ_W'(GRID_SIDE));
      priority if (func_ff > FN_RAY) begin
         op_cls = OP_NOP;
      end else if (outside) begin
         op_cls = OP_OUTSIDE;
      end else begin
         unique case (func_ff)
            FN_SET:    op_cls = OP_SET;
            FN_CLEAR:  op_cls = OP_CLEAR;
            FN_WALL:   op_cls = OP_WALL;
            FN_PILLAR: op_cls = OP_PILLAR;
            FN_RAY:    op_cls = OP_RAY;
            default:   op_cls = OP_NOP;
         endcase
      end
   end

   // Next state and request registers.
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      vs_in    = vs_ff;
      op_in    = op_ff;
      frac_in  = frac_ff;
      dir_in   = dir_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in   = F_CELL;
               func_in    = req_func;
               vs_in      = vs_eff;
               frac_in[0] = req_pos_x[7:0];
               frac_in[1] = req_pos_y[7:0];
               frac_in[2] = req_pos_z[7:0];
               dir_in[0]  = req_dir_x;
               dir_in[1]  = req_dir_y;
               dir_in[2]  = req_dir_z;
            end
         end
         F_CELL: begin
            if (&cdone) begin
               op_in    = op_cls;
               state_in = (op_cls == OP_RAY) ? F_TSET : F_PUSH;
            end
         end
         F_TSET: begin
            if ((&tdone_max) && (&tdone_del)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall = (state_ff != F_IDLE) || clearing;
      t_start   = (state_ff == F_CELL) && (&cdone) && (op_cls == OP_RAY);
      push      = (state_ff == F_PUSH) && !q_full;
      push_cmd.op  = op_ff;
      push_cmd.cx  = CELL_W'(cq[0]);
      push_cmd.cy  = CELL_W'(cq[1]);
      push_cmd.cz  = CELL_W'(cq[2]);
      push_cmd.nx  = dir_ff[0][DIR_W-1];
      push_cmd.ny  = dir_ff[1][DIR_W-1];
      push_cmd.nz  = dir_ff[2][DIR_W-1];
      push_cmd.tmx = tm[0];
      push_cmd.tmy = tm[1];
      push_cmd.tmz = tm[2];
      push_cmd.tdx = td[0];
      push_cmd.tdy = td[1];
      push_cmd.tdz = td[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      vs_ff   <= vs_in;
      op_ff   <= op_in;
      frac_ff <= frac_in;
      dir_ff  <= dir_in;
   end

endmodule
`default_nettype wire

>>> src/vgrt_queue.sv
// Small command queue between the front end and the back end.
`default_nettype none
module vgrt_queue
   import vgrt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = entry_ff[rd_ff];

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

>>> src/vgrt_back.sv
// Back end: owns the occupancy memory, carries out commands and holds the result register.
`default_nettype none
module vgrt_back
   import vgrt_pkg::*;
#(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  cmd_type                  q_data,
   input  wire logic                q_empty,
   output logic                     pop,
   output logic                     clearing,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic     [STATUS_W-1:0]  rsp_status,
   output logic     [HIT_W-1:0]     rsp_hit_x,
   output logic     [HIT_W-1:0]     rsp_hit_y,
   output logic     [HIT_W-1:0]     rsp_hit_z
);
   localparam int ROWS     = GRID_SIDE * GRID_SIDE;
   localparam int AW       = $clog2(ROWS);
   localparam int ZW       = $clog2(GRID_SIDE);
   localparam int LAST_ROW = ROWS - 1;

   // One word per (x, y) row, one bit per z.
   logic [GRID_SIDE-1:0] mem [ROWS];

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CELL_W-1:0]    row_ff, row_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [GRID_SIDE-1:0] rdata_ff;
   status_type           res_status_ff, res_status_in;
   logic [HIT_W-1:0]     res_x_ff, res_x_in, res_y_ff, res_y_in, res_z_ff, res_z_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [HIT_W-1:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   logic                 out_free;
   logic                 pick_x, pick_y;
   logic [CELL_W-1:0]    ncx, ncy, ncz;
   logic [T_W:0]         sum;
   logic [T_W-1:0]       sum_sat;
   logic                 n_out;
   logic                 we;
   logic [AW-1:0]        waddr, raddr;
   logic [GRID_SIDE-1:0] wdata, wmask, zbit;

   function automatic logic [AW-1:0] row_addr(input logic [CELL_W-1:0] x,
                                              input logic [CELL_W-1:0] y);
      return AW'(int'(x) * GRID_SIDE + int'(y));
   endfunction

   function automatic logic in_side(input logic [CELL_W-1:0] c);
      return c < CELL_W'(GRID_SIDE);
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // One DDA step: the strictly smallest tMax wins; a tie goes to z first, then y.
   always_comb begin
      pick_x = (cmd_ff.tmx < cmd_ff.tmy) && (cmd_ff.tmx < cmd_ff.tmz);
      pick_y = !pick_x && (cmd_ff.tmy < cmd_ff.tmz);
      ncx = cmd_ff.cx;
      ncy = cmd_ff.cy;
      ncz = cmd_ff.cz;
      priority if (pick_x) begin
         ncx = cmd_ff.nx ? cmd_ff.cx - CELL_W'(1) : cmd_ff.cx + CELL_W'(1);
         sum = {1'b0, cmd_ff.tmx} + {1'b0, cmd_ff.tdx};
      end else if (pick_y) begin
         ncy = cmd_ff.ny ? cmd_ff.cy - CELL_W'(1) : cmd_ff.cy + CELL_W'(1);
         sum = {1'b0, cmd_ff.tmy} + {1'b0, cmd_ff.tdy};
      end else begin
         ncz = cmd_ff.nz ? cmd_ff.cz - CELL_W'(1) : cmd_ff.cz + CELL_W'(1);
         sum = {1'b0, cmd_ff.tmz} + {1'b0, cmd_ff.tdz};
      end
      sum_sat = sum[T_W] ? T_SAT : sum[T_W-1:0];
      n_out   = !in_side(ncx) || !in_side(ncy) || !in_side(ncz);
   end

   // Next state and data path registers.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      clr_in        = clr_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_z_in      = res_z_ff;
      unique case (state_ff)
         B_CLEAR: begin
            if (clr_ff == AW'(LAST_ROW)) begin
               state_in = B_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               cmd_in        = q_data;
               row_in        = '0;
               res_status_in = ST_DONE;
               res_x_in      = '0;
               res_y_in      = '0;
               res_z_in      = '0;
               unique case (q_data.op)
                  OP_SET, OP_CLEAR: state_in = B_POINT;
                  OP_WALL:          state_in = B_WALL;
                  OP_PILLAR:        state_in = B_PILLAR;
                  OP_RAY:           state_in = B_STEP;
                  OP_OUTSIDE: begin
                     res_status_in = ST_OUTSIDE;
                     state_in      = B_OUT;
                  end
                  default:          state_in = B_OUT;
               endcase
            end
         end
         B_POINT: state_in = B_OUT;
         B_WALL, B_PILLAR: begin
            row_in = row_ff + CELL_W'(1);
            if (row_ff == CELL_W'(GRID_SIDE - 1)) begin
               state_in = B_OUT;
            end
         end
         B_STEP: begin
            cmd_in.cx = ncx;
            cmd_in.cy = ncy;
            cmd_in.cz = ncz;
            priority if (pick_x) begin
               cmd_in.tmx = sum_sat;
            end else if (pick_y) begin
               cmd_in.tmy = sum_sat;
            end else begin
               cmd_in.tmz = sum_sat;
            end
            if (n_out) begin
               res_status_in = ST_RAY_EXIT;
               state_in      = B_OUT;
            end else begin
               state_in = B_TEST;
            end
         end
         B_TEST: begin
            if (rdata_ff[cmd_ff.cz[ZW-1:0]]) begin
               res_x_in = HIT_W'(cmd_ff.cx);
               res_y_in = HIT_W'(cmd_ff.cy);
               res_z_in = HIT_W'(cmd_ff.cz);
               state_in = B_OUT;
            end else begin
               state_in = B_STEP;
            end
         end
         B_OUT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Outputs: queue pop, memory port and result register.
   always_comb begin
      pop      = (state_ff == B_IDLE) && !q_empty;
      clearing = state_ff == B_CLEAR;
      zbit     = GRID_SIDE'(1) << cmd_ff.cz[ZW-1:0];
      we       = 1'b0;
      waddr    = row_addr(cmd_ff.cx, row_ff);
      wdata    = '1;
      wmask    = '1;
      raddr    = row_addr(ncx, ncy);
      unique case (state_ff)
         B_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
         end
         B_POINT: begin
            we    = 1'b1;
            waddr = row_addr(cmd_ff.cx, cmd_ff.cy);
            wdata = (cmd_ff.op == OP_SET) ? '1 : '0;
            wmask = zbit;
         end
         B_WALL: we = 1'b1;
         B_PILLAR: begin
            we    = 1'b1;
            wmask = zbit;
         end
         default: we = 1'b0;
      endcase

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      if ((state_ff == B_OUT) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_x_in      = res_x_ff;
         rsp_y_in      = res_y_ff;
         rsp_z_in      = res_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         for (int j = 0; j < GRID_SIDE; j++) begin
            if (wmask[j]) begin
               mem[waddr][j] <= wdata[j];
            end
         end
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_z_ff      <= res_z_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_hit_x  = rsp_x_ff;
   assign rsp_hit_y  = rsp_y_ff;
   assign rsp_hit_z  = rsp_z_ff;

`ifndef ASSERT_OFF
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_CLEAR) |=> (state_ff != B_CLEAR))
      else $error("clearing pass restarted outside reset");
   a_test_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_TEST) |-> (in_side(cmd_ff.cx) && in_side(cmd_ff.cy)
                                && in_side(cmd_ff.cz)))
      else $error("occupancy tested outside the grid");
   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_OUT))
      else $error("response loaded outside the output state");
`endif

endmodule
`default_nettype wire

>>> src/voxel_grid_ray_traversal.sv
// Top level of the voxel grid ray traversal block.
// The front end finds the cells in serial dividers; a ray adds its t setup in further
// serial dividers, then up to 3*GRID_SIDE DDA steps, each a step state and a test state.
// In the back end, set and clear write one bit; wall and pillar fills write GRID_SIDE rows.
// Throughput: one request per front end pass, limited by the serial dividers; the back end
// runs in parallel behind a queue of QUEUE_DEPTH entries, two by default.
// Reset: synchronous; a clearing pass over all GRID_SIDE*GRID_SIDE rows stalls requests.
`default_nettype none
module voxel_grid_ray_traversal
   import vgrt_pkg::*;
#(
   parameter int GRID_SIDE   = GRID_SIDE_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [VS_W-1:0]     csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [POS_W-1:0]    req_pos_x,
   input  wire logic [POS_W-1:0]    req_pos_y,
   input  wire logic [POS_W-1:0]    req_pos_z,
   input  wire logic [DIR_W-1:0]    req_dir_x,
   input  wire logic [DIR_W-1:0]    req_dir_y,
   input  wire logic [DIR_W-1:0]    req_dir_z,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic     [STATUS_W-1:0]  rsp_status,
   output logic     [HIT_W-1:0]     rsp_hit_x,
   output logic     [HIT_W-1:0]     rsp_hit_y,
   output logic     [HIT_W-1:0]     rsp_hit_z
);
   // The voxel size register; a value of zero is treated as one by the front end.
   logic [VS_W-1:0] voxel_size_ff, voxel_size_in;

   cmd_type push_cmd, pop_cmd;
   logic    push, pop, q_full, q_empty, clearing;

   assign voxel_size_in = csr_wr_en ? csr_wr_data : voxel_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         voxel_size_ff <= VS_RESET;
      end else begin
         voxel_size_ff <= voxel_size_in;
      end
   end

   // The front end classifies each request and computes cells and ray setup.
   vgrt_front #(.GRID_SIDE(GRID_SIDE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_func   (req_func),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_pos_z  (req_pos_z),
      .req_dir_x  (req_dir_x),
      .req_dir_y  (req_dir_y),
      .req_dir_z  (req_dir_z),
      .voxel_size (voxel_size_ff),
      .clearing   (clearing),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Commands wait here so that each side can stall on its own.
   vgrt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   // The back end owns the grid and the result register.
   vgrt_back #(.GRID_SIDE(GRID_SIDE)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (pop_cmd),
      .q_empty    (q_empty),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_hit_x  (rsp_hit_x),
      .rsp_hit_y  (rsp_hit_y),
      .rsp_hit_z  (rsp_hit_z)
   );

endmodule
`default_nettype wire
